FILE: design/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table.
package lpht_pkg;

  localparam int KEY_W = 32;
  localparam int MOD_W = 16;
  localparam int IDX_OUT_W = 4;
  localparam int DIV_CNT_W = 5;
  localparam logic [MOD_W-1:0] MOD_RESET = 16'd13;
  localparam logic [DIV_CNT_W-1:0] KEY_STEPS = 5'd31;

  typedef enum logic [2:0] {
    OUT_FOUND     = 3'd0,
    OUT_ABSENT    = 3'd1,
    OUT_INSERTED  = 3'd2,
    OUT_DUPLICATE = 3'd3,
    OUT_FULL      = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_KEY,
    ST_REDUCE,
    ST_HOME,
    ST_PROBE,
    ST_CHECK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_req;
    logic     div_step;
    logic     load_quot;
    logic     set_home;
    logic     rd_en;
    logic     advance;
    logic     clr_wr;
    logic     key_wr;
    logic     post;
    logic     zero_idx;
    outcome_t code;
  } lpht_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_insert;
    logic div_last;
    logic key_match;
    logic slot_empty;
    logic ptr_last;
    logic cnt_last;
    logic out_free;
  } lpht_sts_t;

endpackage

FILE: design/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lpht_datapath.sv
// Datapath: key and modulus registers, remainder and home-slot units, probe pointer, slot RAM.
module lpht_datapath #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lpht_pkg::MOD_W-1:0]    cfg_wr_data,
  input  logic                          req_type,
  input  logic [lpht_pkg::KEY_W-1:0]    search_key,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [2:0]                    outcome,
  output logic [lpht_pkg::IDX_OUT_W-1:0] slot_index,
  input  lpht_pkg::lpht_cmd_t           cmd,
  output lpht_pkg::lpht_sts_t           sts
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  // (x * RECIP) >> RED_SHIFT is x / TABLE_SIZE for every 16-bit x
  localparam int RED_SHIFT = lpht_pkg::MOD_W + IDX_W;
  localparam int RECIP_W = lpht_pkg::MOD_W + 1;
  localparam int PROD_W = lpht_pkg::MOD_W + RECIP_W;
  localparam int BACK_W = 2 * lpht_pkg::MOD_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RED_SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

  logic [lpht_pkg::MOD_W-1:0]     modulus;
  logic [lpht_pkg::KEY_W-1:0]     key;
  logic                           is_insert;
  logic [lpht_pkg::KEY_W-1:0]     dividend;
  logic [lpht_pkg::MOD_W-1:0]     divisor;
  logic [lpht_pkg::MOD_W-1:0]     rem;
  logic [lpht_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [lpht_pkg::MOD_W-1:0]     quot;
  logic [IDX_W-1:0]               pos;
  logic [IDX_W-1:0]               cnt;
  logic [lpht_pkg::MOD_W:0]       trial;
  logic [lpht_pkg::MOD_W-1:0]     rem_next;
  logic [PROD_W-1:0]              red_prod;
  logic [BACK_W-1:0]              red_back;
  logic [lpht_pkg::MOD_W-1:0]     home_rem;
  logic [IDX_W-1:0]               pos_next;
  logic [lpht_pkg::KEY_W-1:0]     rd_data;
  logic                           ram_we;
  logic [lpht_pkg::KEY_W-1:0]     ram_wdata;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= lpht_pkg::MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  // One restoring remainder step per cycle
  always_comb begin
    trial = {rem, dividend[lpht_pkg::KEY_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = lpht_pkg::MOD_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[lpht_pkg::MOD_W-1:0];
    end
  end

  // Reduction by the table size: quotient by reciprocal, then subtract back
  assign red_prod = PROD_W'(rem) * PROD_W'(RECIP);
  assign red_back = {{lpht_pkg::MOD_W{1'b0}}, quot} * BACK_W'(TABLE_SIZE);
  assign home_rem = rem - red_back[lpht_pkg::MOD_W-1:0];

  // Wrapping probe pointer
  assign pos_next = (pos == IDX_W'(TABLE_SIZE - 1)) ? '0 : pos + 1'b1;

  // Request capture and remainder unit
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      key       <= search_key;
      is_insert <= req_type;
      dividend  <= search_key;
      rem       <= '0;
      divisor   <= (modulus == '0) ? lpht_pkg::MOD_W'(1) : modulus;
      div_cnt   <= lpht_pkg::KEY_STEPS;
    end else if (cmd.load_quot) begin
      quot      <= lpht_pkg::MOD_W'(red_prod >> RED_SHIFT);
    end else if (cmd.div_step) begin
      dividend  <= dividend << 1;
      rem       <= rem_next;
      div_cnt   <= div_cnt - 1'b1;
    end
  end

  // Probe pointer and visit count; pointer also sweeps the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cnt <= '0;
    end else if (cmd.set_home) begin
      pos <= IDX_W'(home_rem);
      cnt <= '0;
    end else if (cmd.advance) begin
      pos <= pos_next;
      cnt <= cnt + 1'b1;
    end
  end

  // Slot storage
  assign ram_we    = cmd.clr_wr | cmd.key_wr;
  assign ram_wdata = cmd.key_wr ? key : '0;

  lpht_ram #(
    .WIDTH (lpht_pkg::KEY_W),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (pos),
    .rdata (rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      outcome    <= cmd.code;
      slot_index <= cmd.zero_idx ? '0 : lpht_pkg::IDX_OUT_W'(pos);
    end
  end

  // Status
  always_comb begin
    sts.is_insert  = is_insert;
    sts.div_last   = (div_cnt == '0);
    sts.key_match  = (rd_data == key);
    sts.slot_empty = (rd_data == '0);
    sts.ptr_last   = (pos == IDX_W'(TABLE_SIZE - 1));
    sts.cnt_last   = (cnt == IDX_W'(TABLE_SIZE - 1));
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

FILE: design/lpht_ctrl.sv
// Controller state machine: clearing pass, remainder pass, home slot, probe walk, result hand-off.
module lpht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpht_pkg::lpht_sts_t sts,
  output lpht_pkg::lpht_cmd_t cmd
);

  lpht_pkg::state_t state;
  lpht_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lpht_pkg::ST_CLEAR: begin
        if (sts.ptr_last) state_next = lpht_pkg::ST_IDLE;
      end
      lpht_pkg::ST_IDLE: begin
        if (in_valid) state_next = lpht_pkg::ST_DIV_KEY;
      end
      lpht_pkg::ST_DIV_KEY: begin
        if (sts.div_last) state_next = lpht_pkg::ST_REDUCE;
      end
      lpht_pkg::ST_REDUCE: begin
        state_next = lpht_pkg::ST_HOME;
      end
      lpht_pkg::ST_HOME: begin
        state_next = lpht_pkg::ST_PROBE;
      end
      lpht_pkg::ST_PROBE: begin
        state_next = lpht_pkg::ST_CHECK;
      end
      lpht_pkg::ST_CHECK: begin
        if (sts.key_match || sts.slot_empty || sts.cnt_last) begin
          if (sts.out_free) state_next = lpht_pkg::ST_IDLE;
        end else begin
          state_next = lpht_pkg::ST_PROBE;
        end
      end
      default: state_next = lpht_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.code = lpht_pkg::OUT_FULL;
    in_ready = 1'b0;
    case (state)
      lpht_pkg::ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.advance = 1'b1;
      end
      lpht_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      lpht_pkg::ST_DIV_KEY: begin
        cmd.div_step = 1'b1;
      end
      lpht_pkg::ST_REDUCE: begin
        cmd.load_quot = 1'b1;
      end
      lpht_pkg::ST_HOME: begin
        cmd.set_home = 1'b1;
      end
      lpht_pkg::ST_PROBE: begin
        cmd.rd_en = 1'b1;
      end
      lpht_pkg::ST_CHECK: begin
        if (sts.key_match) begin
          // a zero key matches the first empty slot here
          cmd.post = sts.out_free;
          cmd.code = sts.is_insert ? lpht_pkg::OUT_DUPLICATE : lpht_pkg::OUT_FOUND;
        end else if (sts.slot_empty) begin
          cmd.post   = sts.out_free;
          cmd.key_wr = sts.out_free && sts.is_insert;
          cmd.code   = sts.is_insert ? lpht_pkg::OUT_INSERTED : lpht_pkg::OUT_ABSENT;
        end else if (sts.cnt_last) begin
          cmd.post     = sts.out_free;
          cmd.zero_idx = 1'b1;
          cmd.code     = lpht_pkg::OUT_FULL;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == lpht_pkg::ST_DIV_KEY))
    else $error("accepted item did not start the remainder pass");

  a_post_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.post |=> (state == lpht_pkg::ST_IDLE))
    else $error("controller did not return to idle after a result");

  a_write_only_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.key_wr |-> (sts.is_insert && sts.slot_empty && !sts.key_match && cmd.post))
    else $error("key written to a slot that is not a free slot for an insert");

  a_full_after_all: assert property (@(posedge clk) disable iff (rst)
    (cmd.post && cmd.code == lpht_pkg::OUT_FULL) |-> sts.cnt_last)
    else $error("full reported before every slot was probed");

  a_no_post_when_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> sts.out_free)
    else $error("result posted over an untaken result");
`endif

endmodule

FILE: design/linear_probe_hash_table.sv
// Linear-probe hash table of nonzero 32-bit keys in TABLE_SIZE slots, zero marking an
// empty slot. After reset a clearing pass writes zero into every slot, one per cycle,
// so in_ready stays low until the pass is done (configuration writes are taken
// throughout). Each item then goes through an accept step, the bit-serial remainder
// by the configured modulus, forming the quotient by TABLE_SIZE with a reciprocal
// multiply, subtracting it back to load the home slot, and a read and a check step per
// probed slot, since the slot RAM has registered read data; between 1 and TABLE_SIZE
// slots are probed, and the last check waits while the previous result is not taken.
// The result sits in an output register, so the next item is accepted while it waits.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] search_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  outcome,
  output logic [3:0]  slot_index,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  lpht_pkg::lpht_cmd_t cmd;
  lpht_pkg::lpht_sts_t sts;

  // Control
  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  lpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (req_type),
    .search_key  (search_key),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .outcome     (outcome),
    .slot_index  (slot_index),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
